// ===== rtl/kfrp_pkg.sv =====
// Package for the keyed Feistel range permutation.
// MD5 round constants, shift amounts and config register indexes; no dependencies.
`default_nettype none
package kfrp_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_RANGE_SIZE  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_VALUE_COUNT = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_KEYED_MODE  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_KEY_ONE     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_KEY_TWO     = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_KEY_THREE   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_KEY_FOUR    = 3'd6;

    localparam logic [31:0] MD5_A0 = 32'h67452301;
    localparam logic [31:0] MD5_B0 = 32'hefcdab89;
    localparam logic [31:0] MD5_C0 = 32'h98badcfe;
    localparam logic [31:0] MD5_D0 = 32'h10325476;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    typedef struct packed {
        logic        start;
        logic [31:0] key;
        logic [15:0] arg;
        logic        two_bytes;
    } t_rf_req;
endpackage
`default_nettype wire

// ===== rtl/keyed_feistel_range_permutation.sv =====
// Top level: keyed pseudorandom permutation of 0..range_size-1.
// Identity mode or an exhausted sequence: S_CHECK, then S_TEST registers the result;
//   keyed mode adds walk attempts, each of 4 Feistel rounds (S_ROUND, S_WAIT) before S_TEST.
// One item at a time: o_stall is high outside S_IDLE, so no new item is taken until the last
//   has left S_OUT; the single MD5 step unit in kfrp_round_fn sets the speed of each round.
// Synchronous active-low reset clears counters, config to defaults, no clearing pass.
`default_nettype none
module keyed_feistel_range_permutation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_restart,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_perm_value,
    output logic [31:0]      o_position,
    output logic             o_is_last,
    output logic             o_error_flag,
    input  wire logic        i_cfg_we,
    input  wire logic [kfrp_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import kfrp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_ROUND, S_WAIT, S_TEST, S_OUT} t_state;

    t_state      r_state;
    logic [31:0] r_range, r_count;
    logic        r_keyed;
    logic [31:0] r_key [4];
    logic [32:0] r_walk;
    logic [31:0] r_emitted;
    logic [15:0] r_x, r_y;
    logic [1:0]  r_round;
    logic [5:0]  r_half;
    logic [15:0] r_mask;
    logic [31:0] r_w, r_n;
    logic        r_start;
    logic        r_tried;

    t_rf_req     w_req;
    logic        w_done;
    logic [15:0] w_rf;
    logic [31:0] w_cand;
    logic [5:0]  w_nb;

    always_comb begin
        w_req.start = r_start;
        w_req.key = r_key[r_round];
        w_req.arg = r_round[0] ? r_y : r_x;
        w_req.two_bytes = r_half > 6'd8;
    end

    kfrp_round_fn u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_result(w_rf)
    );

    // even bit count covering w-1, at least 2
    always_comb begin
        logic [31:0] t;
        t = r_w - 32'd1;
        w_nb = 6'd2;
        for (int i = 31; i >= 1; i--) begin
            if (t[i] && w_nb == 6'd2) w_nb = 6'(i + 1 + ((i + 1) & 1));
        end
        w_cand = (32'(r_x) << r_half) | 32'(r_y);
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        r_start <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_range <= 32'd1; r_count <= '0; r_keyed <= 1'b0;
            r_key[0] <= '0; r_key[1] <= '0; r_key[2] <= '0; r_key[3] <= '0;
            r_walk <= '0; r_emitted <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_RANGE_SIZE:  r_range <= i_cfg_data;
                    REG_VALUE_COUNT: r_count <= i_cfg_data;
                    REG_KEYED_MODE:  r_keyed <= i_cfg_data[0];
                    REG_KEY_ONE:     r_key[0] <= i_cfg_data;
                    REG_KEY_TWO:     r_key[1] <= i_cfg_data;
                    REG_KEY_THREE:   r_key[2] <= i_cfg_data;
                    REG_KEY_FOUR:    r_key[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    if (i_restart) begin r_walk <= '0; r_emitted <= '0; end
                    r_w <= (r_range == '0) ? 32'd1 : r_range;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_n <= (r_count < r_w) ? r_count : r_w;
                    r_half <= w_nb >> 1;
                    r_mask <= 16'((17'd1 << (w_nb >> 1)) - 17'd1);
                    r_state <= S_TEST;
                    r_round <= 2'd3;
                    r_tried <= 1'b0;
                end
                S_ROUND: begin
                    r_start <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_WAIT: if (w_done) begin
                    if (r_round[0]) r_x <= (r_x ^ w_rf) & r_mask;
                    else            r_y <= (r_y ^ w_rf) & r_mask;
                    if (r_round == 2'd3) begin
                        r_tried <= 1'b1;
                        r_state <= S_TEST;
                    end else begin
                        r_round <= r_round + 2'd1;
                        r_state <= S_ROUND;
                    end
                end
                S_TEST: begin
                    // x, y hold the halves of the finished attempt, if any
                    if (r_emitted >= r_n) begin
                        o_perm_value <= '0; o_position <= '0; o_is_last <= 1'b0;
                        o_error_flag <= 1'b1; o_valid <= 1'b1; r_state <= S_OUT;
                    end else if (!r_keyed) begin
                        o_perm_value <= r_emitted; o_position <= r_emitted;
                        o_is_last <= (r_emitted + 32'd1 == r_n);
                        o_error_flag <= 1'b0; o_valid <= 1'b1;
                        r_emitted <= r_emitted + 32'd1; r_state <= S_OUT;
                    end else if (r_tried && w_cand < r_w) begin
                        o_perm_value <= w_cand; o_position <= r_emitted;
                        o_is_last <= (r_emitted + 32'd1 == r_n);
                        o_error_flag <= 1'b0; o_valid <= 1'b1;
                        r_emitted <= r_emitted + 32'd1; r_state <= S_OUT;
                    end else if (r_walk > ((33'd1 << r_half) << r_half) - 33'd1) begin
                        o_perm_value <= '0; o_position <= '0; o_is_last <= 1'b0;
                        o_error_flag <= 1'b1; o_valid <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_x <= r_walk[15:0] & r_mask;
                        r_y <= 16'(r_walk >> r_half) & r_mask;
                        r_walk <= r_walk + 33'd1;
                        r_round <= 2'd0;
                        r_state <= S_ROUND;
                    end
                end
                S_OUT: if (o_valid && !i_stall) begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("result outside output state");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_flag) |-> (o_perm_value == '0 && !o_is_last))
        else $error("error result not cleared");
    a_value_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_error_flag) |-> o_perm_value < r_w) else $error("value out of range");
`endif
endmodule
`default_nettype wire

// ===== rtl/kfrp_round_fn.sv =====
// Feistel round function: one MD5 compression of a short key+arg message,
// one MD5 step per cycle, digest folded to 16 bits. Uses kfrp_pkg.
`default_nettype none
module kfrp_round_fn (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire kfrp_pkg::t_rf_req i_req,
    output logic                  o_done,
    output logic [15:0]           o_result
);
    import kfrp_pkg::*;

    logic        r_busy;
    logic [5:0]  r_step;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_m0, r_m1;
    logic        r_two;
    logic        r_fin;
    logic [15:0] r_result;

    logic [31:0] w_f, w_sum, w_rot, w_m;
    logic [3:0]  w_g;
    logic [31:0] w_m2, w_m14;
    logic [31:0] h0, h1, h2, h3;
    logic [7:0]  w_hi, w_lo;

    always_comb begin
        unique case (r_step[5:4])
            2'd0: begin w_f = (r_b & r_c) | (~r_b & r_d); w_g = r_step[3:0]; end
            2'd1: begin
                w_f = (r_d & r_b) | (~r_d & r_c);
                w_g = 4'(5 * r_step[3:0] + 1);
            end
            2'd2: begin w_f = r_b ^ r_c ^ r_d; w_g = 4'(3 * r_step[3:0] + 5); end
            default: begin w_f = r_c ^ (r_b | ~r_d); w_g = 4'(7 * r_step[3:0]); end
        endcase
        // message words: key, arg + pad, zeros, bit length
        w_m2 = r_two ? 32'd0 : 32'd0;
        w_m14 = r_two ? 32'd48 : 32'd40;
        case (w_g)
            4'd0:  w_m = r_m0;
            4'd1:  w_m = r_m1;
            4'd14: w_m = w_m14;
            default: w_m = w_m2;
        endcase
        w_sum = w_f + r_a + md5_k(r_step) + w_m;
        w_rot = (w_sum << md5_s(r_step)) | (w_sum >> (6'd32 - {1'b0, md5_s(r_step)}));
        h0 = r_a + MD5_A0;
        h1 = r_b + MD5_B0;
        h2 = r_c + MD5_C0;
        h3 = r_d + MD5_D0;
        w_hi = h0[7:0] ^ h0[15:8] ^ h0[23:16] ^ h0[31:24]
             ^ h1[7:0] ^ h1[15:8] ^ h1[23:16] ^ h1[31:24];
        w_lo = h2[7:0] ^ h2[15:8] ^ h2[23:16] ^ h2[31:24]
             ^ h3[7:0] ^ h3[15:8] ^ h3[23:16] ^ h3[31:24];
    end

    always_ff @(posedge i_clk) begin
        r_fin <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_a <= MD5_A0; r_b <= MD5_B0; r_c <= MD5_C0; r_d <= MD5_D0;
            r_m0 <= i_req.key;
            r_two <= i_req.two_bytes;
            r_m1 <= i_req.two_bytes ? {8'h00, 8'h80, i_req.arg}
                                    : {16'h0000, 8'h80, i_req.arg[7:0]};
        end else if (r_busy) begin
            r_a <= r_d; r_d <= r_c; r_c <= r_b;
            r_b <= r_b + w_rot;
            r_step <= r_step + 6'd1;
            if (r_step == 6'd63) begin
                r_busy <= 1'b0;
                r_fin <= 1'b1;
            end
        end
        if (r_fin) r_result <= {w_hi, w_lo};
    end

    // the fold is registered in the cycle after the last step
    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= r_fin;
    end
    assign o_done = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_fin_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> $past(r_busy)) else $error("round done without work");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> o_done) else $error("done lost");
    a_step_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> r_step == 6'd0) else $error("step counter wrong");
`endif
endmodule
`default_nettype wire
